[src/brbmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbmp_pkg: shared types and constants of the byte ring buffer
// Holds the buffer geometry, the command codes, the payload structs and the
// records passed between the sequencer and the drain step unit.
// ----------------------------------------------------------------------------
package brbmp_pkg;

   localparam int unsigned BUFFER_DEPTH = 64;
   localparam int unsigned IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int unsigned FILL_W       = $clog2(BUFFER_DEPTH + 1);
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned TAKEN_W      = 7;
   localparam logic [BYTE_W-1:0] EOM_RESET = 8'd10;

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_POP_MSG = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [BYTE_W-1:0] in_byte;
      logic [BYTE_W-1:0] max_bytes;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               last;
      logic               push_accepted;
      logic [TAKEN_W-1:0] taken_count;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  rd_byte;
      logic [BYTE_W-1:0]  eom;
      logic               message;
      logic [BYTE_W-1:0]  limit;
      logic [TAKEN_W-1:0] emitted;
      logic [FILL_W-1:0]  guard;
      logic [IDX_W-1:0]   rd_idx;
      logic [IDX_W-1:0]   wr_idx;
      logic [FILL_W-1:0]  fill;
   } step_in_type;

   typedef struct packed {
      logic               emit;
      logic               cont;
      logic               last;
      logic [IDX_W-1:0]   rd_idx_next;
      logic [FILL_W-1:0]  fill_next;
      logic [FILL_W-1:0]  guard_next;
      logic [TAKEN_W-1:0] emitted_next;
   } step_out_type;

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i >= IDX_W'(BUFFER_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

endpackage

[src/brbmp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbmp_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module brbmp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/brbmp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbmp_step: one drain step of a pop
// Given the byte just read, decides whether it is emitted, advances the
// read index, fill count and counters, and looks ahead to tell whether
// another byte follows and whether this byte closes the output run.
// ----------------------------------------------------------------------------
module brbmp_step (
   input  brbmp_pkg::step_in_type  step_in,
   output brbmp_pkg::step_out_type step_out
);
   import brbmp_pkg::*;

   logic               stop;
   logic               emit;
   logic               more_room;
   logic [TAKEN_W-1:0] emitted_next;
   logic [IDX_W-1:0]   rd_idx_next;
   logic [FILL_W-1:0]  fill_next;
   logic [FILL_W-1:0]  guard_next;
   logic               cont;

   always_comb begin
      stop         = step_in.message && (step_in.rd_byte == step_in.eom);
      emit         = {{(BYTE_W-TAKEN_W){1'b0}}, step_in.emitted} < step_in.limit;
      emitted_next = step_in.emitted + TAKEN_W'(emit);
      more_room    = {{(BYTE_W-TAKEN_W){1'b0}}, emitted_next} < step_in.limit;
      rd_idx_next  = next_index(step_in.rd_idx);
      fill_next    = step_in.fill - 1'b1;
      guard_next   = step_in.guard + 1'b1;
      // A plain pop stops at its limit; a message pop keeps consuming.
      cont = (guard_next < FILL_W'(BUFFER_DEPTH)) && (fill_next != '0) && !stop &&
             (rd_idx_next != step_in.wr_idx) && (step_in.message || more_room);

      step_out.emit         = emit;
      step_out.cont         = cont;
      step_out.last         = !(cont && more_room);
      step_out.rd_idx_next  = rd_idx_next;
      step_out.fill_next    = fill_next;
      step_out.guard_next   = guard_next;
      step_out.emitted_next = emitted_next;
   end

endmodule

[src/byte_ring_buffer_with_message_pop_core.sv]
`timescale 1ns / 1ps
// Push and clear: the status result is registered and valid in the cycle after the transfer.
// Pop: the first byte passes the registered store read and the result register,
// then one byte per cycle from the single read port of the store while results
// are taken; the FINISH state ends the command and the next request follows.
// Reset clears the indices, fill count and full lock and sets eom_ff to 10.
// The byte store itself is not cleared; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_message_pop_core: ring FIFO of bytes with message pop
// A small sequencer handles push, clear, pop and message pop over a byte
// store, draining one byte per step through the shared step unit.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_message_pop_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  brbmp_pkg::req_type         req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output brbmp_pkg::rsp_type         rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [brbmp_pkg::BYTE_W-1:0] csr_data
);
   import brbmp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EVAL   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               lock_ff, lock_in;
   logic [BYTE_W-1:0]  eom_ff;
   logic               message_ff, message_in;
   logic [BYTE_W-1:0]  limit_ff, limit_in;
   logic [FILL_W-1:0]  guard_ff, guard_in;
   logic [TAKEN_W-1:0] emitted_ff, emitted_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               slot_free;
   logic               req_fire;
   logic               rsp_load;
   logic               run_first;
   logic               is_msg;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [BYTE_W-1:0]  mem_rd_data;
   step_in_type        step_in;
   step_out_type       step_out;
   rsp_type            status_rsp;

   brbmp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_data.in_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      step_in.rd_byte = mem_rd_data;
      step_in.eom     = eom_ff;
      step_in.message = message_ff;
      step_in.limit   = limit_ff;
      step_in.emitted = emitted_ff;
      step_in.guard   = guard_ff;
      step_in.rd_idx  = rd_idx_ff;
      step_in.wr_idx  = wr_idx_ff;
      step_in.fill    = fill_ff;
   end

   brbmp_step u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign is_msg    = (cmd_type'(req_data.command) == CMD_POP_MSG);

   // While locked full the first byte is drained regardless of the limit.
   assign run_first = (fill_ff != '0) &&
                      (lock_ff || ((rd_idx_ff != wr_idx_ff) &&
                                   (is_msg || (req_data.max_bytes != '0))));

   always_comb begin
      status_rsp               = '0;
      status_rsp.last          = 1'b1;

      state_in    = state_ff;
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      fill_in     = fill_ff;
      lock_in     = lock_ff;
      message_in  = message_ff;
      limit_in    = limit_ff;
      guard_in    = guard_ff;
      emitted_in  = emitted_ff;
      rsp_in      = rsp_ff;
      rsp_load    = 1'b0;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd_type'(req_data.command))
                  CMD_PUSH: begin
                     rsp_in   = status_rsp;
                     rsp_load = 1'b1;
                     if (!lock_ff) begin
                        mem_wr_en               = 1'b1;
                        wr_idx_in               = next_index(wr_idx_ff);
                        fill_in                 = fill_ff + 1'b1;
                        lock_in                 = (next_index(wr_idx_ff) == rd_idx_ff);
                        rsp_in.push_accepted    = 1'b1;
                     end
                  end
                  CMD_POP, CMD_POP_MSG: begin
                     message_in = is_msg;
                     limit_in   = req_data.max_bytes;
                     guard_in   = '0;
                     emitted_in = '0;
                     if (run_first) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_EVAL;
                     end else begin
                        rsp_in   = status_rsp;
                        rsp_load = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     wr_idx_in = '0;
                     rd_idx_in = '0;
                     fill_in   = '0;
                     lock_in   = 1'b0;
                     rsp_in    = status_rsp;
                     rsp_load  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVAL: begin
            if (!step_out.emit || slot_free) begin
               rd_idx_in  = step_out.rd_idx_next;
               fill_in    = step_out.fill_next;
               guard_in   = step_out.guard_next;
               emitted_in = step_out.emitted_next;
               if (step_out.emit) begin
                  rsp_in.out_byte      = mem_rd_data;
                  rsp_in.byte_valid    = 1'b1;
                  rsp_in.last          = step_out.last;
                  rsp_in.push_accepted = 1'b0;
                  rsp_in.taken_count   = step_out.emitted_next;
                  rsp_load             = 1'b1;
               end
               if (step_out.cont) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = step_out.rd_idx_next;
               end else begin
                  lock_in  = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               // A pop that emitted nothing still answers with one status result.
               if (emitted_ff == '0) begin
                  rsp_in   = status_rsp;
                  rsp_load = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         fill_ff      <= '0;
         lock_ff      <= 1'b0;
         eom_ff       <= EOM_RESET;
         guard_ff     <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         fill_ff      <= fill_in;
         lock_ff      <= lock_in;
         guard_ff     <= guard_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            eom_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      message_ff <= message_in;
      limit_ff   <= limit_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(BUFFER_DEPTH))
      else $error("fill count exceeds buffer depth");

   a_lock_indices: assert property (@(posedge clock) disable iff (reset)
      (lock_ff && (state_ff == ST_IDLE)) |-> (wr_idx_ff == rd_idx_ff))
      else $error("full lock set while indices differ");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      {{(FILL_W-TAKEN_W){1'b0}}, emitted_ff} <= guard_ff)
      else $error("more bytes emitted than drained");
`endif

endmodule
